// File: hw/rtl/f2i_pkg.sv
// Package: shared types and constants for the float to integer converter.
package f2i_pkg;

    localparam int OP_W  = 3;
    localparam int SRC_W = 64;
    localparam int INT_W = 64;

    // Opcode bit positions
    localparam int OP_SINGLE_BIT   = 2;
    localparam int OP_IS64_BIT     = 1;
    localparam int OP_UNSIGNED_BIT = 0;

    localparam logic [10:0] D_EXP_ALL1 = 11'h7FF;
    localparam logic [10:0] D_BIAS     = 11'd1023;
    localparam logic [10:0] F_EXP_ALL1 = 11'h0FF;
    localparam logic [10:0] F_BIAS     = 11'd127;

    // Result of the decode stage
    typedef struct packed {
        logic        zero;     // magnitude below one
        logic        sat;      // saturate
        logic        neg;
        logic        is64;
        logic        uns;
        logic [5:0]  sh;       // right shift of the left-aligned significand
    } t_dec;

endpackage

// File: hw/rtl/float_to_integer_convert.sv
// Top level: pipelined truncating IEEE 754 to integer converter.
// Three register stages (decode, right shift, negate/saturate), the last of
// which drives the master side; one item enters per cycle unless the input
// is stalled. A stall on the master side holds the whole pipe without loss;
// bubbles are filled when downstream is blocked, so the input stalls only
// once all three stages hold an item and the result waits.
module float_to_integer_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [2:0] opcode, [66:3] source_bits, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] int_value
);
    import f2i_pkg::*;

    logic          r_v1, r_v2, r_v3;
    t_dec          r_d1, r_d2;
    logic [63:0]   r_sig1, r_mag2;
    logic [63:0]   r_out;
    t_dec          dec;
    logic [63:0]   sig;
    logic [63:0]   val;
    logic          adv3, adv2, adv1;

    // Stage advance, filling bubbles under backpressure
    assign adv3 = !r_v3 || m_axis_tready;
    assign adv2 = adv3 || !r_v2;
    assign adv1 = adv2 || !r_v1;
    assign s_axis_tready = adv1;

    f2i_decode u_dec (
        .i_op  (s_axis_tdata[2:0]),
        .i_src (s_axis_tdata[66:3]),
        .o_dec (dec),
        .o_sig (sig)
    );

    f2i_finish u_fin (
        .i_dec (r_d2),
        .i_mag (r_mag2),
        .o_val (val)
    );

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= s_axis_tvalid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_d1   <= dec;
            r_sig1 <= sig;
        end
        if (adv2) begin
            r_d2   <= r_d1;
            r_mag2 <= r_sig1 >> r_d1.sh;
        end
        if (adv3) r_out <= val;
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = r_out;
endmodule

// File: hw/rtl/f2i_decode.sv
// Decode stage: unpack the source, classify it and compute the shift amount.
module f2i_decode (
    input  logic [f2i_pkg::OP_W-1:0]  i_op,
    input  logic [f2i_pkg::SRC_W-1:0] i_src,
    output f2i_pkg::t_dec             o_dec,
    output logic [63:0]               o_sig
);
    import f2i_pkg::*;

    logic        single;
    logic [10:0] efield;
    logic [10:0] e_unb;
    logic        allones;
    logic        below;
    logic [6:0]  lim;

    always_comb begin
        single       = i_op[OP_SINGLE_BIT];
        o_dec.is64   = i_op[OP_IS64_BIT];
        o_dec.uns    = i_op[OP_UNSIGNED_BIT];
        if (single) begin
            o_dec.neg = i_src[31];
            efield    = {3'b0, i_src[30:23]};
            allones   = (efield == F_EXP_ALL1);
            below     = (efield < F_BIAS);
            e_unb     = efield - F_BIAS;
            // significand left-aligned to bit 63
            o_sig     = {1'b1, i_src[22:0], 40'b0};
        end else begin
            o_dec.neg = i_src[63];
            efield    = i_src[62:52];
            allones   = (efield == D_EXP_ALL1);
            below     = (efield < D_BIAS);
            e_unb     = efield - D_BIAS;
            o_sig     = {1'b1, i_src[51:0], 11'b0};
        end
        // exponent limit: width for unsigned, width-1 for signed
        lim        = (o_dec.is64 ? 7'd64 : 7'd32) - {6'b0, ~o_dec.uns};
        o_dec.zero = below && !allones;
        o_dec.sat  = allones || (!below && (e_unb >= {4'b0, lim}))
                     || (o_dec.uns && o_dec.neg);
        // value = sig >> (63 - e); in range e < 64
        o_dec.sh   = 6'd63 - e_unb[5:0];
    end
endmodule

// File: hw/rtl/f2i_finish.sv
// Final stage: negate, saturate and mask to the destination width.
module f2i_finish (
    input  f2i_pkg::t_dec              i_dec,
    input  logic [63:0]                i_mag,
    output logic [f2i_pkg::INT_W-1:0]  o_val
);
    import f2i_pkg::*;

    logic [63:0] wmask;
    logic [63:0] maxv;
    logic [63:0] v;

    always_comb begin
        wmask = i_dec.is64 ? {64{1'b1}} : {32'b0, {32{1'b1}}};
        maxv  = i_dec.uns ? wmask : (wmask >> 1);
        if (i_dec.zero) begin
            v = '0;
        end else if (i_dec.sat) begin
            if (i_dec.uns)
                v = i_dec.neg ? 64'd0 : maxv;
            else
                v = i_dec.neg ? (maxv + 64'd1) : maxv;
        end else begin
            v = i_dec.neg ? (64'd0 - i_mag) : i_mag;
        end
        o_val = v & wmask;
    end
endmodule

// File: hw/rtl/f2i_checker.sv
// Checker: port-level assertions for the converter, bound to the top level.
module f2i_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [71:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // Empty output stage accepts
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("not ready while output empty");

    // Input stalls only behind a waiting result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // Reset empties the output
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind float_to_integer_convert f2i_port_checker u_f2i_checker (.*);
